>>> rtl/core/lhme_pkg.sv
package lhme_pkg;

  localparam int unsigned MAX_SITES_DEFAULT = 16;

  localparam int unsigned SITE_CNT_W = 5;
  localparam int unsigned STRENGTH_W = 16;
  localparam int unsigned ELEMENT_W  = 20;
  localparam int unsigned FACTOR_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MIN_SITES  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SITE_COUNT      = 3'd0,
    CFG_HOP_STRENGTH    = 3'd1,
    CFG_ONSITE_STRENGTH = 3'd2,
    CFG_UP_COUNT_ODD    = 3'd3,
    CFG_DOWN_COUNT_ODD  = 3'd4
  } cfg_reg_e;

  typedef logic signed [FACTOR_W-1:0] factor_t;

endpackage

>>> rtl/core/lhme_hop_factor.sv
module lhme_hop_factor #(
  parameter int unsigned N = lhme_pkg::MAX_SITES_DEFAULT
) (
  input  logic [N-1:0]      bra_i,
  input  logic [N-1:0]      ket_i,
  input  logic [N-1:0]      mask_i,
  input  logic              count_odd_i,
  output lhme_pkg::factor_t factor_o
);
  import lhme_pkg::*;

  logic [N-1:0] diff;
  logic [N-1:0] top;
  logic [N-1:0] match_r;
  logic [N-1:0] match_l;
  logic         right_plain;
  logic         right_wrap;
  logic         left_plain;
  logic         left_wrap;
  factor_t      right_term;
  factor_t      left_term;
  factor_t      wrap_term;

  assign diff = bra_i ^ ket_i;
  assign top  = mask_i & ~(mask_i >> 1);

  // destination site i; right move comes from i-1 (top for site 0),
  // left move comes from i+1 (site 0 for the top site)
  always_comb begin
    logic [N-1:0] dst;
    logic [N-1:0] src_r;
    logic [N-1:0] src_l;
    for (int i = 0; i < N; i++) begin
      dst   = N'(1) << i;
      src_r = (i == 0) ? top : (N'(1) << (i - 1));
      src_l = top[i] ? N'(1) : (N'(1) << (i + 1));
      match_r[i] = mask_i[i] & ~bra_i[i] & (|(bra_i & src_r)) & (diff == (dst | src_r));
      match_l[i] = mask_i[i] & ~bra_i[i] & (|(bra_i & src_l)) & (diff == (dst | src_l));
    end
  end

  assign right_wrap  = match_r[0];
  assign right_plain = |match_r[N-1:1];
  assign left_wrap   = |(match_l & top);
  assign left_plain  = |(match_l & ~top);

  // a boundary move adds minus the boundary sign
  assign wrap_term = count_odd_i ? -3'sd1 : 3'sd1;

  always_comb begin
    right_term = 3'sd0;
    left_term  = 3'sd0;
    if (right_wrap) begin
      right_term = wrap_term;
    end else if (right_plain) begin
      right_term = -3'sd1;
    end
    if (left_wrap) begin
      left_term = wrap_term;
    end else if (left_plain) begin
      left_term = -3'sd1;
    end
  end

  assign factor_o = right_term + left_term;

endmodule

>>> rtl/core/lattice_hopping_matrix_element.sv
// One 1D Hubbard Hamiltonian element per accepted bra/ket pair. A transfer is
// taken whenever start_i is high; busy_o stays low, so a new pair can enter
// in every cycle. The result shows on done_o and the result ports for one
// cycle, once its transfer has passed the input register and then the result
// register; the receiver cannot stall it, so it must take every result when
// done_o is high. The per-site neighbor compares, the occupancy count and the
// one 16-bit by small multiply all sit in the single stage between those two
// registers. Configuration writes take effect on the next cycle and should
// only happen while no pair is in flight.
module lattice_hopping_matrix_element #(
  parameter int unsigned MAX_SITES = lhme_pkg::MAX_SITES_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lhme_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lhme_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [MAX_SITES-1:0]                   bra_up_i,
  input  logic [MAX_SITES-1:0]                   bra_down_i,
  input  logic [MAX_SITES-1:0]                   ket_up_i,
  input  logic [MAX_SITES-1:0]                   ket_down_i,
  output logic                                   done_o,
  output logic signed [lhme_pkg::ELEMENT_W-1:0]  element_value_o,
  output logic signed [lhme_pkg::FACTOR_W-1:0]   up_hop_factor_o,
  output logic signed [lhme_pkg::FACTOR_W-1:0]   down_hop_factor_o
);
  import lhme_pkg::*;

  localparam int unsigned SW     = $clog2(MAX_SITES + 1);
  localparam int unsigned PW     = (SW + 1 > 4) ? SW + 1 : 4;
  localparam int unsigned PROD_W = (STRENGTH_W + PW > ELEMENT_W) ?
                                   STRENGTH_W + PW : ELEMENT_W;

  logic [SITE_CNT_W-1:0]        site_count_q;
  logic signed [STRENGTH_W-1:0] hop_q;
  logic signed [STRENGTH_W-1:0] onsite_q;
  logic                         up_odd_q;
  logic                         down_odd_q;

  logic                 in_valid_q;
  logic [MAX_SITES-1:0] bra_up_q, bra_down_q, ket_up_q, ket_down_q;

  logic                        done_q;
  logic signed [ELEMENT_W-1:0] element_q, element_d;
  factor_t                     up_f_q, up_f_d;
  factor_t                     down_f_q, down_f_d;

  logic [SW-1:0]        eff_sites;
  logic [MAX_SITES-1:0] mask;
  logic                 accept;
  factor_t              up_raw, down_raw;
  logic                 up_same, down_same;
  logic [SW-1:0]        double_cnt;
  logic [MAX_SITES-1:0] double_occ;
  logic signed [PW-1:0] mul_b;
  logic signed [STRENGTH_W-1:0] mul_a;
  logic signed [PROD_W-1:0]     product;
  logic signed [3:0]            factor_sum;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= SITE_CNT_W'(16);
      hop_q        <= 16'sd4096;
      onsite_q     <= 16'sd4096;
      up_odd_q     <= 1'b0;
      down_odd_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SITE_COUNT:      site_count_q <= cfg_wdata_i[SITE_CNT_W-1:0];
        CFG_HOP_STRENGTH:    hop_q        <= cfg_wdata_i;
        CFG_ONSITE_STRENGTH: onsite_q     <= cfg_wdata_i;
        CFG_UP_COUNT_ODD:    up_odd_q     <= cfg_wdata_i[0];
        CFG_DOWN_COUNT_ODD:  down_odd_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(site_count_q) < MIN_SITES) begin
      eff_sites = SW'(MIN_SITES);
    end else if (32'(site_count_q) > MAX_SITES) begin
      eff_sites = SW'(MAX_SITES);
    end else begin
      eff_sites = SW'(site_count_q);
    end
    for (int i = 0; i < MAX_SITES; i++) begin
      mask[i] = (i < int'(eff_sites));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bra_up_q   <= bra_up_i & mask;
      bra_down_q <= bra_down_i & mask;
      ket_up_q   <= ket_up_i & mask;
      ket_down_q <= ket_down_i & mask;
    end
  end

  lhme_hop_factor #(.N(MAX_SITES)) u_up_hop (
    .bra_i       (bra_up_q),
    .ket_i       (ket_up_q),
    .mask_i      (mask),
    .count_odd_i (up_odd_q),
    .factor_o    (up_raw)
  );

  lhme_hop_factor #(.N(MAX_SITES)) u_down_hop (
    .bra_i       (bra_down_q),
    .ket_i       (ket_down_q),
    .mask_i      (mask),
    .count_odd_i (down_odd_q),
    .factor_o    (down_raw)
  );

  assign up_same    = (bra_up_q == ket_up_q);
  assign down_same  = (bra_down_q == ket_down_q);
  assign double_occ = bra_up_q & bra_down_q;

  always_comb begin
    double_cnt = '0;
    for (int i = 0; i < MAX_SITES; i++) begin
      double_cnt = double_cnt + SW'(double_occ[i]);
    end
  end

  always_comb begin
    up_f_d   = 3'sd0;
    down_f_d = 3'sd0;
    if (!(up_same && down_same)) begin
      if (down_same) begin
        up_f_d = up_raw;
      end
      if (up_same) begin
        down_f_d = down_raw;
      end
    end
  end

  assign factor_sum = 4'(up_f_d) + 4'(down_f_d);

  always_comb begin
    if (up_same && down_same) begin
      mul_a = onsite_q;
      mul_b = signed'(PW'(double_cnt));
    end else begin
      mul_a = hop_q;
      mul_b = PW'(factor_sum);
    end
  end

  assign product    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign element_d  = product[ELEMENT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      element_q <= element_d;
      up_f_q    <= up_f_d;
      down_f_q  <= down_f_d;
    end
  end

  assign done_o            = done_q;
  assign element_value_o   = element_q;
  assign up_hop_factor_o   = up_f_q;
  assign down_hop_factor_o = down_f_q;

  a_done_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_q))
    else $error("result strobe without a transfer in flight");

  a_one_spin_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && up_hop_factor_o != 3'sd0) |-> (down_hop_factor_o == 3'sd0))
    else $error("both spins report a hopping factor");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (up_hop_factor_o != 3'sd3 && up_hop_factor_o != -3'sd4 &&
                up_hop_factor_o != -3'sd3 && down_hop_factor_o != 3'sd3 &&
                down_hop_factor_o != -3'sd4 && down_hop_factor_o != -3'sd3))
    else $error("hopping factor outside -2..2");

endmodule

>>> tb/hamiltonian_element_checker.sv
`timescale 1ns / 100ps

module hamiltonian_element_checker #(
  parameter int unsigned MAX_SITES = lhme_pkg::MAX_SITES_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lhme_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lhme_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic [MAX_SITES-1:0]                  bra_up_i,
  input  logic [MAX_SITES-1:0]                  bra_down_i,
  input  logic [MAX_SITES-1:0]                  ket_up_i,
  input  logic [MAX_SITES-1:0]                  ket_down_i,
  input  logic                                  done_i,
  input  logic signed [lhme_pkg::ELEMENT_W-1:0] element_value_i,
  input  logic signed [lhme_pkg::FACTOR_W-1:0]  up_hop_factor_i,
  input  logic signed [lhme_pkg::FACTOR_W-1:0]  down_hop_factor_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  import lhme_pkg::*;

  typedef logic [MAX_SITES-1:0] occ_t;

  typedef struct {
    logic signed [ELEMENT_W-1:0] element;
    factor_t                     up_factor;
    factor_t                     down_factor;
  } matrix_elem_t;

  logic [SITE_CNT_W-1:0]        sites_q;
  logic signed [STRENGTH_W-1:0] hop_q;
  logic signed [STRENGTH_W-1:0] onsite_q;
  logic                         up_odd_q;
  logic                         down_odd_q;

  matrix_elem_t expected_elems[$];

  // Sum of nearest-neighbor moves (right, then left) that turn bra into ket.
  function automatic int hop_count(occ_t bra, occ_t ket, occ_t ring, occ_t top_bit, bit odd);
    int   acc;
    int   bsign;
    occ_t diff;
    occ_t cur;
    occ_t h;
    bit   found;
    acc   = 0;
    bsign = odd ? 1 : -1;
    diff  = bra ^ ket;

    cur = (bra << 1) & ring;
    if ((bra & top_bit) != '0) cur[0] = 1'b1;
    cur   = cur & ~bra;
    found = 1'b0;
    for (int i = 0; i < MAX_SITES; i++) begin
      if (!found && cur[i]) begin
        h = occ_t'(1) << i;
        if (i == 0) begin
          if ((h | top_bit) == diff) begin
            acc   = acc - bsign;
            found = 1'b1;
          end
        end else if ((h | (h >> 1)) == diff) begin
          acc   = acc - 1;
          found = 1'b1;
        end
      end
    end

    cur = bra >> 1;
    if (bra[0]) cur = cur ^ top_bit;
    cur   = cur & ~bra;
    found = 1'b0;
    for (int i = 0; i < MAX_SITES; i++) begin
      if (!found && cur[i]) begin
        h = occ_t'(1) << i;
        if ((h & top_bit) != '0) begin
          if ((top_bit | occ_t'(1)) == diff) begin
            acc   = acc - bsign;
            found = 1'b1;
          end
        end else if ((h | ((h << 1) & ring)) == diff) begin
          acc   = acc - 1;
          found = 1'b1;
        end
      end
    end
    return acc;
  endfunction

  function automatic matrix_elem_t hubbard_element(occ_t bu_in, occ_t bd_in, occ_t ku_in,
                                                   occ_t kd_in);
    matrix_elem_t res;
    int           nsites;
    occ_t         top_bit;
    occ_t         ring;
    occ_t         bu;
    occ_t         bd;
    occ_t         ku;
    occ_t         kd;
    int           uf;
    int           df;
    longint       prod;
    nsites = int'(sites_q);
    if (nsites < MIN_SITES) nsites = MIN_SITES;
    if (nsites > MAX_SITES) nsites = MAX_SITES;
    top_bit = occ_t'(1) << (nsites - 1);
    ring    = top_bit | (top_bit - occ_t'(1));
    bu = bu_in & ring;
    bd = bd_in & ring;
    ku = ku_in & ring;
    kd = kd_in & ring;
    uf = 0;
    df = 0;
    if (bu == ku && bd == kd) begin
      prod = longint'(onsite_q) * longint'($countones(bu & bd));
    end else begin
      if (bd == kd) uf = hop_count(bu, ku, ring, top_bit, up_odd_q);
      if (bu == ku) df = hop_count(bd, kd, ring, top_bit, down_odd_q);
      prod = longint'(hop_q) * longint'(uf + df);
    end
    res.element     = prod[ELEMENT_W-1:0];
    res.up_factor   = uf[FACTOR_W-1:0];
    res.down_factor = df[FACTOR_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    matrix_elem_t exp_elem;
    if (!rst_ni) begin
      sites_q      <= SITE_CNT_W'(MAX_SITES_DEFAULT);
      hop_q        <= 16'sd4096;
      onsite_q     <= 16'sd4096;
      up_odd_q     <= 1'b0;
      down_odd_q   <= 1'b0;
      expected_elems.delete();
      fail_count_o = 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SITE_COUNT:      sites_q    <= cfg_wdata_i[SITE_CNT_W-1:0];
          CFG_HOP_STRENGTH:    hop_q      <= cfg_wdata_i;
          CFG_ONSITE_STRENGTH: onsite_q   <= cfg_wdata_i;
          CFG_UP_COUNT_ODD:    up_odd_q   <= cfg_wdata_i[0];
          CFG_DOWN_COUNT_ODD:  down_odd_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (done_i) begin
        if (expected_elems.size() == 0) begin
          $display("%0t: unexpected result, expected none, got element_value %0d", $time,
                   element_value_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_elem = expected_elems.pop_front();
          if (element_value_i !== exp_elem.element) begin
            $display("%0t: element_value expected %0d, got %0d", $time, exp_elem.element,
                     element_value_i);
            fail_count_o = fail_count_o + 1;
          end
          if (up_hop_factor_i !== exp_elem.up_factor) begin
            $display("%0t: up_hop_factor expected %0d, got %0d", $time, exp_elem.up_factor,
                     up_hop_factor_i);
            fail_count_o = fail_count_o + 1;
          end
          if (down_hop_factor_i !== exp_elem.down_factor) begin
            $display("%0t: down_hop_factor expected %0d, got %0d", $time,
                     exp_elem.down_factor, down_hop_factor_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end

      if (start_i && !busy_i) begin
        expected_elems.push_back(hubbard_element(bra_up_i, bra_down_i, ket_up_i, ket_down_i));
      end
      pending_o <= expected_elems.size();
    end
  end

endmodule

>>> tb/lattice_hopping_matrix_element_tb.sv
`timescale 1ns / 100ps

module lattice_hopping_matrix_element_tb;
  import lhme_pkg::*;

  localparam int NSITES     = MAX_SITES_DEFAULT;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_LEN  = 48;
  localparam int IDLE_LIMIT = 2000;

  typedef logic [NSITES-1:0] occ_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;
  logic                         start_i;
  logic                         busy_o;
  occ_t                         bra_up_i;
  occ_t                         bra_down_i;
  occ_t                         ket_up_i;
  occ_t                         ket_down_i;
  logic                         done_o;
  logic signed [ELEMENT_W-1:0]  element_value_o;
  logic signed [FACTOR_W-1:0]   up_hop_factor_o;
  logic signed [FACTOR_W-1:0]   down_hop_factor_o;

  int fail_count;
  int pending;
  int site_tab [NUM_PHASES] = '{2, 3, 16, 0, 1, 17, 31, 5, 8, 15, 12};

  lattice_hopping_matrix_element #(
    .MAX_SITES(NSITES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .bra_up_i         (bra_up_i),
    .bra_down_i       (bra_down_i),
    .ket_up_i         (ket_up_i),
    .ket_down_i       (ket_down_i),
    .done_o           (done_o),
    .element_value_o  (element_value_o),
    .up_hop_factor_o  (up_hop_factor_o),
    .down_hop_factor_o(down_hop_factor_o)
  );

  hamiltonian_element_checker #(
    .MAX_SITES(NSITES)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .bra_up_i         (bra_up_i),
    .bra_down_i       (bra_down_i),
    .ket_up_i         (ket_up_i),
    .ket_down_i       (ket_down_i),
    .done_i           (done_o),
    .element_value_i  (element_value_o),
    .up_hop_factor_i  (up_hop_factor_o),
    .down_hop_factor_i(down_hop_factor_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_pair(input occ_t bu, input occ_t bd, input occ_t ku, input occ_t kd,
                           input int gap);
    start_i    <= 1'b1;
    bra_up_i   <= bu;
    bra_down_i <= bd;
    ket_up_i   <= ku;
    ket_down_i <= kd;
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int sites, input int hop, input int onsite,
                               input bit up_odd, input bit down_odd);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SITE_COUNT;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:SITE_CNT_W], sites[SITE_CNT_W-1:0]};
    @(posedge clk_i);
    cfg_index_i <= CFG_HOP_STRENGTH;
    cfg_wdata_i <= hop[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_index_i <= CFG_ONSITE_STRENGTH;
    cfg_wdata_i <= onsite[CFG_DATA_W-1:0];
    @(posedge clk_i);
    junk = $urandom;
    cfg_index_i <= CFG_UP_COUNT_ODD;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:1], up_odd};
    @(posedge clk_i);
    junk = $urandom;
    cfg_index_i <= CFG_DOWN_COUNT_ODD;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:1], down_odd};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Move one electron from site s to a ring neighbor; junk kept above the ring.
  task automatic hop_one(input int nsites, input occ_t ring, inout occ_t b, inout occ_t k);
    int s;
    int n;
    s = $urandom_range(0, nsites - 1);
    n = $urandom_range(0, 1) ? (s + 1) % nsites : (s + nsites - 1) % nsites;
    b[s] = 1'b1;
    b[n] = 1'b0;
    k    = (b & ring) | (k & ~ring);
    k[s] = 1'b0;
    k[n] = 1'b1;
  endtask

  task automatic make_pair(input int nsites, output occ_t bu, output occ_t bd,
                           output occ_t ku, output occ_t kd);
    occ_t ring;
    int   kind;
    ring = (nsites >= NSITES) ? '1 : (occ_t'(1) << nsites) - occ_t'(1);
    bu   = $urandom;
    bd   = $urandom;
    ku   = $urandom;
    kd   = $urandom;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        ku = (bu & ring) | (ku & ~ring);
        kd = (bd & ring) | (kd & ~ring);
      end
      2, 3, 4, 5: begin
        kd = (bd & ring) | (kd & ~ring);
        hop_one(nsites, ring, bu, ku);
      end
      6, 7: begin
        ku = (bu & ring) | (ku & ~ring);
        hop_one(nsites, ring, bd, kd);
      end
      8: ;
      default: begin
        // both spins hop, or one site flips so the count changes
        if ($urandom_range(0, 1)) begin
          hop_one(nsites, ring, bu, ku);
          hop_one(nsites, ring, bd, kd);
        end else begin
          ku = bu ^ (occ_t'(1) << $urandom_range(0, nsites - 1));
          kd = (bd & ring) | (kd & ~ring);
        end
      end
    endcase
  endtask

  initial begin
    int   idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lattice_hopping_matrix_element_tb: FAIL");
    $finish;
  end

  initial begin
    occ_t bu;
    occ_t bd;
    occ_t ku;
    occ_t kd;
    int   eff_sites;
    int   hop;
    int   onsite;
    bit   up_odd;
    bit   down_odd;
    bit   burst;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_SITE_COUNT;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    bra_up_i    <= '0;
    bra_down_i  <= '0;
    ket_up_i    <= '0;
    ket_down_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full ring, closed-shell boundary sign
    send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, pick_gap(0));
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, pick_gap(0));
    send_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, pick_gap(0));
    send_pair(16'h0001, 16'h0000, 16'h0002, 16'h0000, pick_gap(0));
    send_pair(16'h0002, 16'h0000, 16'h0001, 16'h0000, pick_gap(0));
    send_pair(16'h8000, 16'h1234, 16'h0001, 16'h1234, pick_gap(0));
    send_pair(16'h0001, 16'h0000, 16'h8000, 16'h0000, pick_gap(0));
    send_pair(16'hFFFF, 16'h0100, 16'hFFFF, 16'h0200, pick_gap(0));
    send_pair(16'h0000, 16'h8000, 16'h0000, 16'h0001, pick_gap(0));
    send_pair(16'h0001, 16'h0001, 16'h0002, 16'h0002, pick_gap(0));
    send_pair(16'h0001, 16'h0000, 16'h0004, 16'h0000, pick_gap(0));
    send_pair(16'h0001, 16'h0000, 16'h0003, 16'h0000, pick_gap(0));
    send_pair(16'h7FFF, 16'h0F0F, 16'hFFFE, 16'h0F0F, pick_gap(0));
    send_pair(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, pick_gap(0));
    send_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, pick_gap(0));
    send_pair(16'h0000, 16'hFFFE, 16'h0000, 16'h7FFF, pick_gap(0));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          hop = 32767; onsite = -32768; up_odd = 1'b1; down_odd = 1'b0;
        end
        1: begin
          hop = -32768; onsite = 32767; up_odd = 1'b0; down_odd = 1'b1;
        end
        2: begin
          hop = -32768; onsite = -32768; up_odd = 1'b1; down_odd = 1'b1;
        end
        3: begin
          hop = -1; onsite = 0; up_odd = 1'b0; down_odd = 1'b0;
        end
        default: begin
          hop      = $signed(16'($urandom));
          onsite   = $signed(16'($urandom));
          up_odd   = $urandom_range(0, 1);
          down_odd = $urandom_range(0, 1);
        end
      endcase
      apply_setting(site_tab[phase], hop, onsite, up_odd, down_odd);
      eff_sites = site_tab[phase];
      if (eff_sites < MIN_SITES) eff_sites = MIN_SITES;
      if (eff_sites > NSITES) eff_sites = NSITES;
      burst = 1'b0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 12 == 0) burst = ($urandom_range(0, 3) == 0);
        make_pair(eff_sites, bu, bd, ku, kd);
        send_pair(bu, bd, ku, kd, pick_gap(burst));
      end
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("lattice_hopping_matrix_element_tb: PASS");
    end else begin
      $display("lattice_hopping_matrix_element_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> lattice_hopping_matrix_element.f
rtl/core/lhme_pkg.sv
rtl/core/lhme_hop_factor.sv
rtl/core/lattice_hopping_matrix_element.sv
tb/hamiltonian_element_checker.sv
tb/lattice_hopping_matrix_element_tb.sv
